FILE: hw/rtl/bankers_resource_allocator_unit_defines.svh
// Assertion macros for the banker's resource allocator.
// Included by the top level; no other dependencies.
`ifndef BANKERS_RESOURCE_ALLOCATOR_UNIT_DEFINES_SVH
`define BANKERS_RESOURCE_ALLOCATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge out of reset.
`define BRA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define BRA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BRA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define BRA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/bra_pkg.sv
// Shared types, codes and helpers of the banker's resource allocator.
// No dependencies.
`default_nettype none
package bra_pkg;

    localparam int AMT_W       = 16;
    localparam int NRES_FIELDS = 4;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 72;
    localparam logic [AMT_W-1:0] SAT_MAX = '1;

    typedef enum logic [2:0] {
        ACT_SET_AVAIL = 3'd0,
        ACT_LOAD_MAX  = 3'd1,
        ACT_REQUEST   = 3'd2,
        ACT_RELEASE   = 3'd3,
        ACT_RUN       = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        STS_OK           = 3'd0,
        STS_BAD_CUSTOMER = 3'd1,
        STS_EXCEEDS_NEED = 3'd2,
        STS_EXCEEDS_AVL  = 3'd3,
        STS_UNSAFE       = 3'd4,
        STS_EXCEEDS_ALC  = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_RESP,
        ST_RET_RD,
        ST_RET_EMIT
    } t_state;

    // Unsigned add that sticks at the top of the range.
    function automatic logic [AMT_W-1:0] sat_add16(input logic [AMT_W-1:0] a,
                                                   input logic [AMT_W-1:0] b);
        logic [AMT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[AMT_W] ? SAT_MAX : s[AMT_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/bra_row_mem.sv
// One row-wide synchronous store with registered read and write-first forwarding.
// Rows read as zero until written; valid bits are cleared by reset.
`default_nettype none
module bra_row_mem #(
    parameter int DEPTH = 8,
    parameter int AW    = 3,
    parameter int WIDTH = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [WIDTH-1:0] r_rdata;

    // Storage array.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Per-row valid bits, so that reset reads back as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    // Registered read; a write to the same row in the same cycle is forwarded.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                r_rdata <= i_wdata;
            end else if (r_valid[i_raddr]) begin
                r_rdata <= r_mem[i_raddr];
            end else begin
                r_rdata <= '0;
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: hw/rtl/bankers_resource_allocator_unit.sv
// Top level of the banker's resource allocator: sequencer, vectors, output word.
// Uses bra_pkg, bra_row_mem and the assertion macro header.
//
//  channel   | direction | handshake                   | content
//  s_axis    | in        | tvalid/tready               | action, customer, amounts
//  m_axis    | out       | tvalid/tready, tlast        | status, sequence entry, available
//  apb       | in        | psel/penable, pready high   | customers_in_use at address 0
//
// Set available goes from idle straight to the response state; load and release pass
// through the check state first. A request refused early also ends after the check;
// otherwise the safety scan reads one customer row per cycle from the maximum and
// allocated stores, restarting after every pick, until all active customers retire
// or a whole pass finds none. Run reads and then emits each retired customer in turn.
// Reset is synchronous; the row stores clear through per-row valid bits at once. A
// result waits in the output register while the next word may be accepted.
`default_nettype none
`include "bankers_resource_allocator_unit_defines.svh"
module bankers_resource_allocator_unit
    import bra_pkg::*;
#(
    parameter int CUSTOMERS = 8,
    parameter int RESOURCES = 4
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Input words.
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // tdata from bit 0: customer[3:0], amount_0..amount_3 (16 bits each), zero pad.
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser from bit 0: action[2:0].
    input  wire logic [2:0]             s_axis_tuser,
    // Result words.
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // tdata from bit 0: seq_customer[2:0], avail_0..avail_3 (16 bits each), zero pad.
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // tuser from bit 0: status[2:0], seq_valid.
    output logic [3:0]                  m_axis_tuser,
    output logic                        m_axis_tlast,
    // Configuration port.
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [2:0]             paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int CW    = (CUSTOMERS > 1) ? $clog2(CUSTOMERS) : 1;
    localparam int NW    = $clog2(CUSTOMERS + 1);
    localparam int ROW_W = RESOURCES * AMT_W;

    typedef logic [RESOURCES-1:0][AMT_W-1:0] t_row;

    // Registers.
    t_state             r_state, n_state;
    t_action            r_action, n_action;
    logic [3:0]         r_cust, n_cust;
    t_row               r_amt, n_amt;
    t_row               r_avail, n_avail;
    t_row               r_work, n_work;
    t_row               r_trial, n_trial;
    logic [CUSTOMERS-1:0] r_finish, n_finish;
    logic [CW-1:0]      r_c, n_c;
    logic [NW-1:0]      r_cnt, n_cnt;
    logic [CW-1:0]      r_seq [CUSTOMERS];
    logic [CW-1:0]      n_seq [CUSTOMERS];
    logic [CW-1:0]      r_k, n_k;
    t_status            r_status, n_status;
    logic [3:0]         r_cfg_n;
    logic               r_ovalid, n_ovalid;
    t_status            r_o_status, n_o_status;
    logic               r_o_seqv, n_o_seqv;
    logic [CW-1:0]      r_o_seqc, n_o_seqc;
    logic               r_o_last, n_o_last;
    t_row               r_o_avail, n_o_avail;

    // Store ports.
    logic               rd_en;
    logic [CW-1:0]      rd_addr;
    logic               max_we;
    logic               alloc_we;
    logic [CW-1:0]      alloc_waddr;
    t_row               alloc_wdata;
    logic [ROW_W-1:0]   max_rd_flat, alloc_rd_flat;
    t_row               max_rd, alloc_rd;

    logic               in_accept;
    logic               out_free;
    logic               cfg_wr;
    logic [3:0]         n_act4;
    logic [NW-1:0]      n_act;
    logic               cust_ok;
    logic               exceed_need, exceed_avail, exceed_alloc;
    logic               row_fits, pick, pass_end, ret_last;
    t_row               trial_row, sub_row, rel_row, rel_avail, pick_work;
    t_row               ret_avail, back_avail, back_alloc;
    logic signed [AMT_W:0] need [RESOURCES];

    assign max_rd   = t_row'(max_rd_flat);
    assign alloc_rd = t_row'(alloc_rd_flat);

    bra_row_mem #(.DEPTH(CUSTOMERS), .AW(CW), .WIDTH(ROW_W)) u_max_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (max_we),
        .i_waddr (r_cust[CW-1:0]),
        .i_wdata (ROW_W'(r_amt)),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (max_rd_flat)
    );

    bra_row_mem #(.DEPTH(CUSTOMERS), .AW(CW), .WIDTH(ROW_W)) u_alloc_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (alloc_we),
        .i_waddr (alloc_waddr),
        .i_wdata (ROW_W'(alloc_wdata)),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (alloc_rd_flat)
    );

    // Configuration register.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_n <= 4'(CUSTOMERS);
        end else if (cfg_wr && !paddr[2]) begin
            r_cfg_n <= pwdata[3:0];
        end
    end

    assign prdata = paddr[2] ? 32'd0 : {28'd0, r_cfg_n};

    // Active customer count, clamped into range.
    always_comb begin
        if (r_cfg_n == 4'd0) begin
            n_act4 = 4'd1;
        end else if (r_cfg_n > 4'(CUSTOMERS)) begin
            n_act4 = 4'(CUSTOMERS);
        end else begin
            n_act4 = r_cfg_n;
        end
    end
    assign n_act   = NW'(n_act4);
    assign cust_ok = r_cust < n_act4;

    // Row arithmetic on the word under check and the row being scanned.
    always_comb begin
        exceed_need  = 1'b0;
        exceed_avail = 1'b0;
        exceed_alloc = 1'b0;
        row_fits     = 1'b1;
        for (int r = 0; r < RESOURCES; r++) begin
            need[r] = $signed({1'b0, max_rd[r]}) - $signed({1'b0, alloc_rd[r]});
            if ($signed({1'b0, r_amt[r]}) > need[r]) exceed_need = 1'b1;
            if (r_amt[r] > r_avail[r]) exceed_avail = 1'b1;
            if (r_amt[r] > alloc_rd[r]) exceed_alloc = 1'b1;
            if (need[r] > $signed({1'b0, r_work[r]})) row_fits = 1'b0;
            trial_row[r]  = sat_add16(alloc_rd[r], r_amt[r]);
            sub_row[r]    = r_avail[r] - r_amt[r];
            rel_row[r]    = alloc_rd[r] - r_amt[r];
            rel_avail[r]  = sat_add16(r_avail[r], r_amt[r]);
            pick_work[r]  = sat_add16(r_work[r], alloc_rd[r]);
            ret_avail[r]  = sat_add16(r_avail[r], alloc_rd[r]);
            back_avail[r] = sat_add16(r_avail[r], r_amt[r]);
            back_alloc[r] = r_trial[r] - r_amt[r];
        end
    end

    assign pick     = !r_finish[r_c] && row_fits;
    assign pass_end = (NW'(r_c) == (n_act - NW'(1)));
    assign ret_last = (NW'(r_k) == (n_act - NW'(1)));

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);

    // Sequencer: next state, store accesses and result word.
    always_comb begin
        n_state    = r_state;
        n_action   = r_action;
        n_cust     = r_cust;
        n_amt      = r_amt;
        n_avail    = r_avail;
        n_work     = r_work;
        n_trial    = r_trial;
        n_finish   = r_finish;
        n_c        = r_c;
        n_cnt      = r_cnt;
        n_seq      = r_seq;
        n_k        = r_k;
        n_status   = r_status;
        n_ovalid   = r_ovalid && !m_axis_tready;
        n_o_status = r_o_status;
        n_o_seqv   = r_o_seqv;
        n_o_seqc   = r_o_seqc;
        n_o_last   = r_o_last;
        n_o_avail  = r_o_avail;
        rd_en      = 1'b0;
        rd_addr    = '0;
        max_we     = 1'b0;
        alloc_we   = 1'b0;
        alloc_waddr = r_cust[CW-1:0];
        alloc_wdata = rel_row;

        case (r_state)
            ST_IDLE: begin
                rd_en   = in_accept;
                rd_addr = s_axis_tdata[CW-1:0];
                if (in_accept) begin
                    n_action = t_action'(s_axis_tuser);
                    n_cust   = s_axis_tdata[3:0];
                    for (int r = 0; r < RESOURCES; r++) begin
                        n_amt[r] = s_axis_tdata[4 + AMT_W*r +: AMT_W];
                    end
                    case (t_action'(s_axis_tuser))
                        ACT_SET_AVAIL: begin
                            n_avail  = n_amt;
                            n_status = STS_OK;
                            n_state  = ST_RESP;
                        end
                        ACT_LOAD_MAX, ACT_REQUEST, ACT_RELEASE: begin
                            n_state = ST_CHECK;
                        end
                        ACT_RUN: begin
                            n_work   = r_avail;
                            n_finish = '0;
                            n_cnt    = '0;
                            n_c      = '0;
                            rd_addr  = '0;
                            n_state  = ST_SCAN;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_CHECK: begin
                n_state = ST_RESP;
                if (!cust_ok) begin
                    n_status = STS_BAD_CUSTOMER;
                end else begin
                    case (r_action)
                        ACT_LOAD_MAX: begin
                            max_we   = 1'b1;
                            n_status = STS_OK;
                        end
                        ACT_REQUEST: begin
                            if (exceed_need) begin
                                n_status = STS_EXCEEDS_NEED;
                            end else if (exceed_avail) begin
                                n_status = STS_EXCEEDS_AVL;
                            end else begin
                                // Trial allocation, then the safety scan.
                                alloc_we    = 1'b1;
                                alloc_wdata = trial_row;
                                n_trial     = trial_row;
                                n_avail     = sub_row;
                                n_work      = sub_row;
                                n_finish    = '0;
                                n_cnt       = '0;
                                n_c         = '0;
                                rd_en       = 1'b1;
                                rd_addr     = '0;
                                n_state     = ST_SCAN;
                            end
                        end
                        ACT_RELEASE: begin
                            if (exceed_alloc) begin
                                n_status = STS_EXCEEDS_ALC;
                            end else begin
                                alloc_we    = 1'b1;
                                alloc_wdata = rel_row;
                                n_avail     = rel_avail;
                                n_status    = STS_OK;
                            end
                        end
                        default: begin
                            n_status = STS_OK;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                if (pick) begin
                    n_work          = pick_work;
                    n_finish[r_c]   = 1'b1;
                    n_seq[r_cnt[CW-1:0]] = r_c;
                    n_cnt           = r_cnt + NW'(1);
                    if (n_cnt == n_act) begin
                        // Every active customer retired: the state is safe.
                        if (r_action == ACT_RUN) begin
                            n_k     = '0;
                            n_state = ST_RET_RD;
                        end else begin
                            n_status = STS_OK;
                            n_state  = ST_RESP;
                        end
                    end else begin
                        n_c     = '0;
                        rd_en   = 1'b1;
                        rd_addr = '0;
                    end
                end else if (pass_end) begin
                    // A whole pass without a pick: unsafe.
                    n_status = STS_UNSAFE;
                    n_state  = ST_RESP;
                    if (r_action != ACT_RUN) begin
                        alloc_we    = 1'b1;
                        alloc_wdata = back_alloc;
                        n_avail     = back_avail;
                    end
                end else begin
                    n_c     = r_c + CW'(1);
                    rd_en   = 1'b1;
                    rd_addr = n_c;
                end
            end

            ST_RESP: begin
                if (out_free) begin
                    n_ovalid   = 1'b1;
                    n_o_status = r_status;
                    n_o_seqv   = 1'b0;
                    n_o_seqc   = '0;
                    n_o_last   = 1'b1;
                    n_o_avail  = r_avail;
                    n_state    = ST_IDLE;
                end
            end

            ST_RET_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_seq[r_k];
                n_state = ST_RET_EMIT;
            end

            ST_RET_EMIT: begin
                if (out_free) begin
                    // Retire this customer: give back its allocation.
                    n_avail     = ret_avail;
                    alloc_we    = 1'b1;
                    alloc_waddr = r_seq[r_k];
                    alloc_wdata = '0;
                    n_ovalid    = 1'b1;
                    n_o_status  = STS_OK;
                    n_o_seqv    = 1'b1;
                    n_o_seqc    = r_seq[r_k];
                    n_o_last    = ret_last;
                    n_o_avail   = ret_avail;
                    if (ret_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_k     = r_k + CW'(1);
                        n_state = ST_RET_RD;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_avail  <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_avail  <= n_avail;
        end
    end

    // Payload and scratch registers.
    always_ff @(posedge i_clk) begin
        r_action   <= n_action;
        r_cust     <= n_cust;
        r_amt      <= n_amt;
        r_work     <= n_work;
        r_trial    <= n_trial;
        r_finish   <= n_finish;
        r_c        <= n_c;
        r_cnt      <= n_cnt;
        r_seq      <= n_seq;
        r_k        <= n_k;
        r_status   <= n_status;
        r_o_status <= n_o_status;
        r_o_seqv   <= n_o_seqv;
        r_o_seqc   <= n_o_seqc;
        r_o_last   <= n_o_last;
        r_o_avail  <= n_o_avail;
    end

    // Result word packing.
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tuser  = {r_o_seqv, r_o_status};

    always_comb begin
        m_axis_tdata      = '0;
        m_axis_tdata[2:0] = 3'(r_o_seqc);
        for (int r = 0; r < RESOURCES; r++) begin
            m_axis_tdata[3 + AMT_W*r +: AMT_W] = r_o_avail[r];
        end
    end

    // Checks on the sequencer.
    `BRA_ASSERT_IMP(a_retire_full, i_clk, i_rst_n, (r_state == ST_RET_RD), (r_cnt == n_act), "retire started without a full safe sequence")
    `BRA_ASSERT_IMP(a_scan_range, i_clk, i_rst_n, (r_state == ST_SCAN), (NW'(r_c) < n_act), "scan index beyond the active customers")
    `BRA_ASSERT_IMP(a_seq_ok, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tuser[3]), (m_axis_tuser[2:0] == STS_OK), "sequence entry with a failing status")
    `BRA_ASSERT_NXT(a_retire_next, i_clk, i_rst_n, (r_state == ST_RET_EMIT && out_free && !ret_last), (r_state == ST_RET_RD), "retire did not move to the next customer")

endmodule
`default_nettype wire

FILE: bench/tb_bankers_resource_allocator_unit.sv
// Self-checking bench for the banker's resource allocator: directed table, then random words.
// Depends on bra_pkg and bankers_resource_allocator_unit.
`timescale 1ns / 100ps
`default_nettype none
module tb_bankers_resource_allocator_unit
    import bra_pkg::*;
;

    localparam int NCUST = 8;
    localparam int NRES = 4;
    localparam int CYCLE_LIMIT = 400000;

    // One expected or observed result word.
    typedef struct packed {
        logic [2:0]  status;
        logic        seq_valid;
        logic [2:0]  seq_cust;
        logic        last;
        logic [15:0] av0;
        logic [15:0] av1;
        logic [15:0] av2;
        logic [15:0] av3;
    } t_result;

    // One stimulus row; chk asks for a typed-in status check on a one-word result.
    typedef struct {
        logic [2:0]  act;
        logic [3:0]  cust;
        logic [15:0] amt [NRES];
        logic        chk;
        t_status     sts;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic [3:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    bankers_resource_allocator_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow state of the allocator.
    logic [15:0] avail_sh [NRES];
    logic [15:0] max_sh [NCUST][NRES];
    logic [15:0] alloc_sh [NCUST][NRES];
    logic [3:0]  cust_reg;
    t_result     expected_words [$];
    int          error_count = 0;
    int          cycle_count = 0;
    t_row        rows [$];

    function automatic logic [15:0] sat16(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    function automatic int active_rows();
        int n;
        n = cust_reg;
        if (n < 1) n = 1;
        if (n > NCUST) n = NCUST;
        return n;
    endfunction

    function automatic t_result make_word(input t_status s, input logic sv,
                                          input logic [2:0] sc, input logic lst);
        t_result w;
        w.status = s;
        w.seq_valid = sv;
        w.seq_cust = sc;
        w.last = lst;
        w.av0 = avail_sh[0];
        w.av1 = avail_sh[1];
        w.av2 = avail_sh[2];
        w.av3 = avail_sh[3];
        return w;
    endfunction

    // Safe-sequence search over the shadow tables; returns the retire order length.
    function automatic int find_safe_order(input int n, output int order [NCUST]);
        logic [15:0] work [NRES];
        logic [NCUST-1:0] done;
        int cnt;
        int pick;
        bit fits;
        cnt = 0;
        done = '0;
        for (int r = 0; r < NRES; r++) work[r] = avail_sh[r];
        forever begin
            pick = -1;
            for (int c = 0; c < n && pick < 0; c++) begin
                if (!done[c]) begin
                    fits = 1;
                    for (int r = 0; r < NRES; r++)
                        if (int'(max_sh[c][r]) - int'(alloc_sh[c][r]) > int'(work[r]))
                            fits = 0;
                    if (fits) pick = c;
                end
            end
            if (pick < 0) break;
            for (int r = 0; r < NRES; r++) work[r] = sat16(work[r], alloc_sh[pick][r]);
            done[pick] = 1'b1;
            order[cnt] = pick;
            cnt++;
        end
        return cnt;
    endfunction

    // Applies one accepted word to the shadow state and queues its results.
    task automatic predict_allocator(input logic [2:0] act, input logic [3:0] cust,
                                     input logic [15:0] amt [NRES]);
        int n;
        int order [NCUST];
        bit ok;
        bit bad;
        n = active_rows();
        ok = cust < n;
        bad = 0;
        case (act)
            ACT_SET_AVAIL: begin
                for (int r = 0; r < NRES; r++) avail_sh[r] = amt[r];
                expected_words.push_back(make_word(STS_OK, 0, 0, 1));
            end
            ACT_LOAD_MAX: begin
                if (!ok) begin
                    expected_words.push_back(make_word(STS_BAD_CUSTOMER, 0, 0, 1));
                end else begin
                    for (int r = 0; r < NRES; r++) max_sh[cust][r] = amt[r];
                    expected_words.push_back(make_word(STS_OK, 0, 0, 1));
                end
            end
            ACT_REQUEST: begin
                if (!ok) begin
                    expected_words.push_back(make_word(STS_BAD_CUSTOMER, 0, 0, 1));
                    return;
                end
                for (int r = 0; r < NRES; r++)
                    if (int'(amt[r]) > int'(max_sh[cust][r]) - int'(alloc_sh[cust][r]))
                        bad = 1;
                if (bad) begin
                    expected_words.push_back(make_word(STS_EXCEEDS_NEED, 0, 0, 1));
                    return;
                end
                for (int r = 0; r < NRES; r++) if (amt[r] > avail_sh[r]) bad = 1;
                if (bad) begin
                    expected_words.push_back(make_word(STS_EXCEEDS_AVL, 0, 0, 1));
                    return;
                end
                for (int r = 0; r < NRES; r++) begin
                    avail_sh[r] = avail_sh[r] - amt[r];
                    alloc_sh[cust][r] = sat16(alloc_sh[cust][r], amt[r]);
                end
                if (find_safe_order(n, order) != n) begin
                    for (int r = 0; r < NRES; r++) begin
                        avail_sh[r] = sat16(avail_sh[r], amt[r]);
                        alloc_sh[cust][r] = alloc_sh[cust][r] - amt[r];
                    end
                    expected_words.push_back(make_word(STS_UNSAFE, 0, 0, 1));
                end else begin
                    expected_words.push_back(make_word(STS_OK, 0, 0, 1));
                end
            end
            ACT_RELEASE: begin
                if (!ok) begin
                    expected_words.push_back(make_word(STS_BAD_CUSTOMER, 0, 0, 1));
                    return;
                end
                for (int r = 0; r < NRES; r++) if (amt[r] > alloc_sh[cust][r]) bad = 1;
                if (bad) begin
                    expected_words.push_back(make_word(STS_EXCEEDS_ALC, 0, 0, 1));
                    return;
                end
                for (int r = 0; r < NRES; r++) begin
                    alloc_sh[cust][r] = alloc_sh[cust][r] - amt[r];
                    avail_sh[r] = sat16(avail_sh[r], amt[r]);
                end
                expected_words.push_back(make_word(STS_OK, 0, 0, 1));
            end
            ACT_RUN: begin
                if (find_safe_order(n, order) != n) begin
                    expected_words.push_back(make_word(STS_UNSAFE, 0, 0, 1));
                    return;
                end
                for (int k = 0; k < n; k++) begin
                    for (int r = 0; r < NRES; r++) begin
                        avail_sh[r] = sat16(avail_sh[r], alloc_sh[order[k]][r]);
                        alloc_sh[order[k]][r] = '0;
                    end
                    expected_words.push_back(make_word(STS_OK, 1, 3'(order[k]), k == n - 1));
                end
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        error_count++;
    endtask

    // Random gap length: mostly short, sometimes long.
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side: random stall, then check each accepted word.
    int          stall_count = 0;
    bit          stall_on = 1'b0;
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status = m_axis_tuser[2:0];
            got.seq_valid = m_axis_tuser[3];
            got.seq_cust = m_axis_tdata[2:0];
            got.last = m_axis_tlast;
            got.av0 = m_axis_tdata[18:3];
            got.av1 = m_axis_tdata[34:19];
            got.av2 = m_axis_tdata[50:35];
            got.av3 = m_axis_tdata[66:51];
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word", 64'(got), 0);
            end else begin
                want = expected_words.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.seq_valid !== want.seq_valid)
                    report_mismatch("seq_valid", got.seq_valid, want.seq_valid);
                if (got.seq_cust !== want.seq_cust)
                    report_mismatch("seq_customer", got.seq_cust, want.seq_cust);
                if (got.last !== want.last)
                    report_mismatch("last", got.last, want.last);
                if (got.av0 !== want.av0) report_mismatch("avail_0", got.av0, want.av0);
                if (got.av1 !== want.av1) report_mismatch("avail_1", got.av1, want.av1);
                if (got.av2 !== want.av2) report_mismatch("avail_2", got.av2, want.av2);
                if (got.av3 !== want.av3) report_mismatch("avail_3", got.av3, want.av3);
            end
        end
        // Stall stretches: tready stays high until stall_on is set, then drops for random gaps.
        if (stall_count > 0) begin
            stall_count <= stall_count - 1;
            m_axis_tready <= 1'b0;
        end else if (stall_on && $urandom_range(0, 3) == 0) begin
            stall_count <= gap_len();
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Timeout guard.
    always @(posedge i_clk) begin
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Sends one word with a random gap ahead of it and updates the prediction.
    // Valid stays high after acceptance until a gap or an idle wait drops it.
    task automatic send_word(input logic [2:0] act, input logic [3:0] cust,
                             input logic [15:0] amt [NRES], input bit use_gap);
        int g;
        g = use_gap ? gap_len() : 0;
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= {4'd0, amt[3], amt[2], amt[1], amt[0], cust};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_allocator(act, cust, amt);
    endtask

    // Register write while idle: drains results, lets the block settle, then APB write.
    task automatic write_customers(input logic [3:0] v);
        s_axis_tvalid <= 1'b0;
        wait (expected_words.size() == 0);
        repeat (120) @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= '0;
        pwdata <= 32'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cust_reg = v;
    endtask

    function automatic t_row row(input logic [2:0] a, input logic [3:0] c,
                                 input logic [15:0] x0, input logic [15:0] x1,
                                 input logic [15:0] x2, input logic [15:0] x3,
                                 input logic chk, input t_status s);
        t_row t;
        t.act = a;
        t.cust = c;
        t.amt[0] = x0;
        t.amt[1] = x1;
        t.amt[2] = x2;
        t.amt[3] = x3;
        t.chk = chk;
        t.sts = s;
        return t;
    endfunction

    // Random amount, mostly small so that requests get through.
    function automatic logic [15:0] rand_amt(input int hi);
        int p;
        p = $urandom_range(0, 19);
        if (p == 0) return 16'hFFFF;
        if (p == 1) return 16'($urandom);
        return 16'($urandom_range(0, hi));
    endfunction

    initial begin
        logic [15:0] a [NRES];
        int idx;
        int n;
        int pick;
        for (int r = 0; r < NRES; r++) avail_sh[r] = '0;
        for (int c = 0; c < NCUST; c++)
            for (int r = 0; r < NRES; r++) begin
                max_sh[c][r] = '0;
                alloc_sh[c][r] = '0;
            end
        cust_reg = 4'd8;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: errors, extremes, saturation, negative need, unknown actions.
        rows.push_back(row(ACT_RUN, 0, 0, 0, 0, 0, 0, STS_OK));
        rows.push_back(row(ACT_REQUEST, 4'd15, 0, 0, 0, 0, 1, STS_BAD_CUSTOMER));
        rows.push_back(row(ACT_LOAD_MAX, 4'd8, 1, 1, 1, 1, 1, STS_BAD_CUSTOMER));
        rows.push_back(row(ACT_RELEASE, 4'd9, 0, 0, 0, 0, 1, STS_BAD_CUSTOMER));
        rows.push_back(row(ACT_REQUEST, 0, 1, 0, 0, 0, 1, STS_EXCEEDS_NEED));
        rows.push_back(row(ACT_RELEASE, 0, 0, 0, 0, 1, 1, STS_EXCEEDS_ALC));
        rows.push_back(row(ACT_SET_AVAIL, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, STS_OK));
        rows.push_back(row(ACT_LOAD_MAX, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, STS_OK));
        rows.push_back(row(ACT_LOAD_MAX, 7, 10, 10, 10, 10, 1, STS_OK));
        rows.push_back(row(ACT_REQUEST, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, STS_OK));
        rows.push_back(row(ACT_REQUEST, 7, 5, 5, 5, 5, 0, STS_OK));
        rows.push_back(row(ACT_RELEASE, 7, 3, 0, 1, 2, 0, STS_OK));
        rows.push_back(row(ACT_LOAD_MAX, 7, 0, 0, 0, 0, 0, STS_OK));
        rows.push_back(row(ACT_REQUEST, 7, 1, 0, 0, 0, 1, STS_EXCEEDS_NEED));
        rows.push_back(row(3'd5, 0, 1, 2, 3, 4, 0, STS_OK));
        rows.push_back(row(3'd7, 4'd15, 16'hAAAA, 16'h5555, 0, 16'hFFFF, 0, STS_OK));
        rows.push_back(row(ACT_RUN, 0, 0, 0, 0, 0, 0, STS_OK));
        rows.push_back(row(ACT_SET_AVAIL, 0, 2, 2, 2, 2, 1, STS_OK));
        rows.push_back(row(ACT_LOAD_MAX, 1, 9, 9, 9, 9, 0, STS_OK));
        rows.push_back(row(ACT_REQUEST, 1, 3, 0, 0, 0, 1, STS_EXCEEDS_AVL));
        rows.push_back(row(ACT_REQUEST, 1, 2, 2, 2, 2, 1, STS_UNSAFE));
        rows.push_back(row(ACT_RUN, 0, 0, 0, 0, 0, 0, STS_OK));
        stall_on = 1'b1;
        foreach (rows[i]) begin
            idx = expected_words.size();
            send_word(rows[i].act, rows[i].cust, rows[i].amt, 1);
            if (rows[i].chk && expected_words.size() == idx + 1 &&
                expected_words[idx].status !== rows[i].sts)
                report_mismatch("table status", expected_words[idx].status, rows[i].sts);
        end

        // Random phases across several customer counts, extremes included.
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_customers(4'd1);
                1: write_customers(4'd0);
                2: write_customers(4'd15);
                3: write_customers(4'd3);
                default: write_customers(4'd8);
            endcase
            n = active_rows();
            // Well-formed setup: generous available, maxima, then traffic.
            for (int r = 0; r < NRES; r++) a[r] = 16'($urandom_range(20, 200));
            send_word(ACT_SET_AVAIL, 0, a, 1);
            for (int c = 0; c < n; c++) begin
                for (int r = 0; r < NRES; r++) a[r] = 16'($urandom_range(0, 120));
                send_word(ACT_LOAD_MAX, 4'(c), a, 1);
            end
            for (int k = 0; k < 14; k++) begin
                pick = $urandom_range(0, 99);
                for (int r = 0; r < NRES; r++) a[r] = rand_amt(40);
                if (pick < 45) begin
                    send_word(ACT_REQUEST, 4'($urandom_range(0, n - 1)), a, 1);
                end else if (pick < 65) begin
                    send_word(ACT_RELEASE, 4'($urandom_range(0, n - 1)), a, 1);
                end else if (pick < 78) begin
                    send_word(ACT_RUN, 4'($urandom), a, 1);
                end else if (pick < 85) begin
                    send_word(ACT_LOAD_MAX, 4'($urandom), a, 1);
                end else if (pick < 90) begin
                    send_word(ACT_SET_AVAIL, 4'($urandom), a, 1);
                end else if (pick < 96) begin
                    send_word(3'($urandom_range(0, 3)), 4'($urandom), a, 1);
                end else begin
                    send_word(3'($urandom_range(5, 7)), 4'($urandom), a, 1);
                end
            end
            send_word(ACT_RUN, 0, a, 1);
        end

        // Drain, then allow for trailing work.
        s_axis_tvalid <= 1'b0;
        wait (expected_words.size() == 0);
        repeat (150) @(posedge i_clk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire
